@@ rtl/dmm_pkg.sv @@
// Shared widths and item mode codes for the duration min/max/mean monitor.
package dmm_pkg;

  localparam int TS_W     = 64;
  localparam int CNT_W    = 32;
  localparam int US_W     = 55;
  localparam int CAT_IN_W = 3;
  localparam int MODE_W   = 2;
  localparam int STEP_W   = $clog2(TS_W);

  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

endpackage

@@ rtl/duration_min_max_mean_monitor_top.sv @@
// Top level of the power-transition duration min/max/mean monitor.
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+----------------------
//   in      | mode, category, start_ns, now_ns          | in_valid & in_ready
//   out     | event_count, mean_us, max_us, min_us,     | out_valid & out_ready
//           | enabled                                   |
//   cfg     | cfg_data (enable)                         | cfg_write
//
// Record: capture duration, then update category entry. Clear, ignored: handled in idle.
// Query: loaded into the output register once the 64 one-bit steps of the mean division
// are done; max and min are scaled meanwhile, 8 bits a step.
// Reset clears the enable register and marks every category entry empty.
// A query result waits in the output register; a new item is taken meanwhile,
// and a following query holds in its last step until the register is free.
module duration_min_max_mean_monitor_top
  import dmm_pkg::*;
#(
  parameter int NUM_CATEGORIES = 7,
  parameter int NS_PER_UNIT    = 1000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic [CAT_IN_W-1:0] category,
  input  logic [TS_W-1:0]     start_ns,
  input  logic [TS_W-1:0]     now_ns,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CNT_W-1:0]    event_count,
  output logic [US_W-1:0]     mean_us,
  output logic [US_W-1:0]     max_us,
  output logic [US_W-1:0]     min_us,
  output logic                enabled
);

  localparam int CAT_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int NSU_W = $clog2(NS_PER_UNIT + 1);
  localparam int DVS_W = CNT_W + NSU_W;

  localparam int DIG_W    = 8;
  localparam int CD_STEPS = TS_W / DIG_W;
  localparam int CDS_W    = $clog2(CD_STEPS);
  localparam int RCP_K    = 2 * NSU_W + DIG_W;
  localparam int T_W      = NSU_W + DIG_W;
  localparam int M_W      = RCP_K - NSU_W + 2;
  localparam int P_W      = T_W + M_W;
  localparam logic [M_W-1:0] RCP_M =
    M_W'(((64'd1 << RCP_K) + 64'(NS_PER_UNIT) - 64'd1) / 64'(NS_PER_UNIT));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REC   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [CNT_W-1:0] cnt_mem [NUM_CATEGORIES];
  logic [TS_W-1:0]  tot_mem [NUM_CATEGORIES];
  logic [TS_W-1:0]  max_mem [NUM_CATEGORIES];
  logic [TS_W-1:0]  min_mem [NUM_CATEGORIES];
  logic [NUM_CATEGORIES-1:0] valid;

  logic [2:0]          state;
  logic                enable;
  logic [CAT_IN_W-1:0] cat_reg;
  logic [TS_W-1:0]     d_reg;
  logic [US_W-1:0]     max_q;
  logic [US_W-1:0]     min_q;

  logic                cd_busy;
  logic                cd_sel;
  logic [CDS_W-1:0]    cd_step;
  logic [TS_W-1:0]     cd_val;
  logic [NSU_W-1:0]    cd_rem;
  logic [TS_W-1:0]     cd_quo;

  logic [CAT_W-1:0] idx;
  logic             cat_ok;
  logic             hit;
  logic             in_cat_ok;
  logic [CNT_W-1:0] rd_cnt;
  logic [TS_W-1:0]  rd_tot;
  logic [TS_W-1:0]  rd_max;
  logic [TS_W-1:0]  rd_min;
  logic             div_start;
  logic [TS_W-1:0]  div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [TS_W-1:0]  div_quo;
  logic             out_free;
  logic [T_W-1:0]   cd_t;
  logic [P_W-1:0]   cd_prod;
  logic [DIG_W-1:0] cd_q;
  logic [T_W-1:0]   cd_r;
  logic [TS_W-1:0]  cd_quo_next;
  logic             cd_last;

  assign in_ready  = (state == ST_IDLE);
  assign in_cat_ok = (int'(category) < NUM_CATEGORIES);
  assign cat_ok    = (int'(cat_reg) < NUM_CATEGORIES);
  assign idx       = CAT_W'(cat_reg);
  assign hit       = cat_ok && valid[idx];
  assign rd_cnt    = hit ? cnt_mem[idx] : '0;
  assign rd_tot    = hit ? tot_mem[idx] : '0;
  assign rd_max    = hit ? max_mem[idx] : '0;
  assign rd_min    = hit ? min_mem[idx] : '0;
  assign out_free  = !out_valid || out_ready;

  assign div_start    = (state == ST_START);
  assign div_dividend = rd_tot;
  assign div_divisor  = DVS_W'(rd_cnt) * DVS_W'(NS_PER_UNIT);

  assign cd_t        = {cd_rem, cd_val[TS_W-1 -: DIG_W]};
  assign cd_prod     = P_W'(cd_t) * P_W'(RCP_M);
  assign cd_q        = cd_prod[RCP_K +: DIG_W];
  assign cd_r        = cd_t - T_W'(cd_q) * T_W'(NS_PER_UNIT);
  assign cd_quo_next = {cd_quo[TS_W-DIG_W-1:0], cd_q};
  assign cd_last     = (cd_step == CDS_W'(CD_STEPS - 1));

  dmm_div #(
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      enable    <= 1'b0;
      valid     <= '0;
      out_valid <= 1'b0;
      cd_busy   <= 1'b0;
    end else begin
      if (cfg_write) begin
        enable <= cfg_data;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_START) begin
        cd_busy <= 1'b1;
      end else if (cd_busy && cd_last && cd_sel) begin
        cd_busy <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (mode)
              MODE_RECORD: begin
                if (enable && in_cat_ok) begin
                  state <= ST_REC;
                end
              end
              MODE_CLEAR: valid <= '0;
              MODE_QUERY: state <= ST_START;
              default: ;
            endcase
          end
        end
        ST_REC: begin
          valid[idx] <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cat_reg <= category;
      d_reg   <= now_ns - start_ns;
    end
    if (state == ST_REC) begin
      cnt_mem[idx] <= rd_cnt + 1'b1;
      tot_mem[idx] <= rd_tot + d_reg;
      max_mem[idx] <= (rd_max < d_reg) ? d_reg : rd_max;
      min_mem[idx] <= (rd_min == '0 || rd_min > d_reg) ? d_reg : rd_min;
    end
    if (state == ST_START) begin
      cd_val  <= rd_max;
      cd_rem  <= '0;
      cd_step <= '0;
      cd_sel  <= 1'b0;
    end else if (cd_busy) begin
      cd_quo <= cd_quo_next;
      if (cd_last) begin
        cd_val  <= rd_min;
        cd_rem  <= '0;
        cd_step <= '0;
        cd_sel  <= 1'b1;
        if (cd_sel) begin
          min_q <= cd_quo_next[US_W-1:0];
        end else begin
          max_q <= cd_quo_next[US_W-1:0];
        end
      end else begin
        cd_val  <= cd_val << DIG_W;
        cd_rem  <= cd_r[NSU_W-1:0];
        cd_step <= cd_step + 1'b1;
      end
    end
    if (state == ST_OUT && out_free) begin
      event_count <= rd_cnt;
      mean_us     <= (rd_cnt == '0) ? '0 : div_quo[US_W-1:0];
      max_us      <= max_q;
      min_us      <= min_q;
      enabled     <= enable;
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside a query division");

  a_scale_ahead: assert property (@(posedge clk) disable iff (rst)
    div_done |-> !cd_busy)
    else $error("max and min scaling still running at end of mean division");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result raised without a load step");

  a_mean_needs_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && mean_us != '0 |-> event_count != '0)
    else $error("nonzero mean reported for an empty category");

  a_max_ge_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> max_us >= min_us)
    else $error("reported maximum below reported minimum");
`endif

endmodule

@@ rtl/dmm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, used for the query mean.
module dmm_div
  import dmm_pkg::*;
#(
  parameter int DVS_W = 52
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TS_W-1:0]  dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [TS_W-1:0]  quotient
);

  logic [TS_W-1:0]   quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  assign trial    = {rem, quo[TS_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(TS_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      step <= '0;
    end else if (busy) begin
      quo  <= {quo[TS_W-2:0], ge};
      rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      step <= step + 1'b1;
    end
  end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the duration min/max/mean monitor: directed and random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dmm_pkg::*;

  localparam int NUM_CAT      = 7;
  localparam int NS_PER_US    = 1000;
  localparam int DRAIN_CYCLES = 220;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;
  localparam logic [CAT_IN_W-1:0] CAT_NONE    = 3'd7;
  localparam logic [TS_W-1:0]     TS_MAX      = '1;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [CAT_IN_W-1:0] category;
    logic [TS_W-1:0]     start_ns;
    logic [TS_W-1:0]     now_ns;
  } in_item_t;

  typedef struct {
    logic [CNT_W-1:0] event_count;
    logic [US_W-1:0]  mean_us;
    logic [US_W-1:0]  max_us;
    logic [US_W-1:0]  min_us;
    logic             enabled;
  } stats_reply_t;

  class duration_scoreboard;
    bit [CNT_W-1:0] counts[NUM_CAT];
    bit [TS_W-1:0]  totals[NUM_CAT];
    bit [TS_W-1:0]  longest[NUM_CAT];
    bit [TS_W-1:0]  shortest[NUM_CAT];
    bit             enable_reg;
    stats_reply_t   awaited[$];
    int             errors;

    function void clear_stats();
      foreach (counts[i]) begin
        counts[i] = 0;
        totals[i] = 0;
        longest[i] = 0;
        shortest[i] = 0;
      end
    endfunction

    function bit [US_W-1:0] to_us(bit [TS_W-1:0] ns);
      bit [TS_W-1:0] q;
      q = ns / NS_PER_US;
      return q[US_W-1:0];
    endfunction

    function void note_input(in_item_t it);
      bit [TS_W-1:0] d;
      bit [TS_W-1:0] mean;
      stats_reply_t r;
      d = it.now_ns - it.start_ns;
      case (it.mode)
        MODE_RECORD: begin
          if (enable_reg && it.category < NUM_CAT) begin
            counts[it.category] = counts[it.category] + 1;
            totals[it.category] = totals[it.category] + d;
            if (longest[it.category] < d) longest[it.category] = d;
            if (shortest[it.category] == 0 || shortest[it.category] > d)
              shortest[it.category] = d;
          end
        end
        MODE_CLEAR: clear_stats();
        MODE_QUERY: begin
          r = '{event_count: '0, mean_us: '0, max_us: '0, min_us: '0, enabled: enable_reg};
          if (it.category < NUM_CAT) begin
            mean = (counts[it.category] != 0) ? totals[it.category] / counts[it.category] : '0;
            r.event_count = counts[it.category];
            r.mean_us = to_us(mean);
            r.max_us = to_us(longest[it.category]);
            r.min_us = to_us(shortest[it.category]);
          end
          awaited.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(stats_reply_t got);
      stats_reply_t exp;
      if (awaited.size() == 0) begin
        report("result with no query pending");
      end else begin
        exp = awaited.pop_front();
        if (got.event_count !== exp.event_count)
          report($sformatf("event_count %0d, expected %0d", got.event_count, exp.event_count));
        if (got.mean_us !== exp.mean_us)
          report($sformatf("mean_us %0d, expected %0d", got.mean_us, exp.mean_us));
        if (got.max_us !== exp.max_us)
          report($sformatf("max_us %0d, expected %0d", got.max_us, exp.max_us));
        if (got.min_us !== exp.min_us)
          report($sformatf("min_us %0d, expected %0d", got.min_us, exp.min_us));
        if (got.enabled !== exp.enabled)
          report($sformatf("enabled %0b, expected %0b", got.enabled, exp.enabled));
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic                cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   mode;
  logic [CAT_IN_W-1:0] category;
  logic [TS_W-1:0]     start_ns;
  logic [TS_W-1:0]     now_ns;
  logic                out_valid;
  logic                out_ready;
  logic [CNT_W-1:0]    event_count;
  logic [US_W-1:0]     mean_us;
  logic [US_W-1:0]     max_us;
  logic [US_W-1:0]     min_us;
  logic                enabled;

  duration_scoreboard sb = new();
  int send_idle;
  int recv_idle;
  int hold_left;
  int cycles;

  duration_min_max_mean_monitor_top #(
    .NUM_CATEGORIES(NUM_CAT),
    .NS_PER_UNIT(NS_PER_US)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .category(category),
    .start_ns(start_ns),
    .now_ns(now_ns),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_count(event_count),
    .mean_us(mean_us),
    .max_us(max_us),
    .min_us(min_us),
    .enabled(enabled)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result('{event_count: event_count, mean_us: mean_us, max_us: max_us,
                          min_us: min_us, enabled: enabled});
    end
  end

  function automatic in_item_t make_item(logic [MODE_W-1:0] m, logic [CAT_IN_W-1:0] c,
                                         logic [TS_W-1:0] s, logic [TS_W-1:0] n);
    in_item_t it;
    it.mode = m;
    it.category = c;
    it.start_ns = s;
    it.now_ns = n;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    logic [TS_W-1:0] span;
    pick = $urandom_range(99);
    if (pick < 58) it.mode = MODE_RECORD;
    else if (pick < 60) it.mode = MODE_CLEAR;
    else if (pick < 62) it.mode = MODE_UNUSED;
    else it.mode = MODE_QUERY;
    it.category = ($urandom_range(99) < 6) ? CAT_NONE : CAT_IN_W'($urandom_range(NUM_CAT - 1));
    it.start_ns = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 5) span = '0;
    else if (pick < 50) span = TS_W'($urandom_range(20000));
    else if (pick < 80) span = {22'd0, 10'($urandom_range(1023)), 32'($urandom)};
    else span = {$urandom, $urandom};
    it.now_ns = it.start_ns + span;
    return it;
  endfunction

  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode = it.mode;
    category = it.category;
    start_ns = it.start_ns;
    now_ns = it.now_ns;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) send(random_item());
  endtask

  // hold input, wait out pending queries and any trailing record
  task automatic drain();
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_enable(logic v);
    drain();
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.enable_reg = v;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    mode = MODE_RECORD;
    category = '0;
    start_ns = '0;
    now_ns = '0;
    hold_left = 0;
    send_idle = 18;
    recv_idle = 61;
    sb.clear_stats();
    sb.enable_reg = 1'b0;
    sb.errors = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // disabled after reset: record is dropped
    send(make_item(MODE_RECORD, 3'd0, 64'd100, 64'd5100));
    send(make_item(MODE_QUERY, 3'd0, '0, '0));
    set_enable(1'b1);

    send(make_item(MODE_QUERY, 3'd6, '0, '0));
    send(make_item(MODE_RECORD, 3'd0, 64'd777, 64'd777));
    send(make_item(MODE_QUERY, 3'd0, '0, '0));
    send(make_item(MODE_RECORD, 3'd0, 64'd1000, 64'd4000));
    send(make_item(MODE_RECORD, 3'd0, 64'd2000, 64'd3500));
    send(make_item(MODE_QUERY, 3'd0, '0, '0));
    send(make_item(MODE_RECORD, 3'd1, TS_MAX, 64'd0));
    send(make_item(MODE_RECORD, 3'd1, 64'd0, TS_MAX));
    send(make_item(MODE_QUERY, 3'd1, '0, '0));
    send(make_item(MODE_RECORD, CAT_NONE, 64'd0, 64'd9000));
    send(make_item(MODE_QUERY, CAT_NONE, '0, '0));
    send(make_item(MODE_UNUSED, 3'd2, TS_MAX, TS_MAX));
    send(make_item(MODE_RECORD, 3'd6, 64'h8000_0000_0000_0000, 64'h8000_0000_0012_3456));
    send(make_item(MODE_RECORD, 3'd5, TS_MAX - 64'd2000, TS_MAX));
    send(make_item(MODE_QUERY, 3'd6, '0, '0));
    send(make_item(MODE_QUERY, 3'd5, '0, '0));
    send(make_item(MODE_QUERY, 3'd2, '0, '0));
    send(make_item(MODE_CLEAR, 3'd4, '0, '0));
    send(make_item(MODE_QUERY, 3'd0, '0, '0));
    send(make_item(MODE_QUERY, 3'd6, '0, '0));
    send(make_item(MODE_RECORD, 3'd4, 64'd50, 64'd250050));
    send(make_item(MODE_QUERY, 3'd4, '0, '0));

    send_random(300);
    // stall the receiver while queries keep coming
    hold_left = 1500;
    repeat (12) send(make_item(MODE_QUERY, CAT_IN_W'($urandom_range(NUM_CAT)), '0, '0));
    send_random(400);

    set_enable(1'b0);
    send_idle = 61;
    recv_idle = 18;
    send_random(150);
    set_enable(1'b1);
    send_random(550);

    drain();
    send_idle = 0;
    recv_idle = 0;
    send_random(450);
    set_enable(1'b0);
    send_random(60);
    set_enable(1'b1);
    send_random(50);

    drain();
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d queries without a result", sb.awaited.size()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dmm_pkg.sv
rtl/dmm_div.sv
rtl/duration_min_max_mean_monitor_top.sv
bench/testbench.sv
